/* hdl/utf8_safe_text_checker_defines.svh */
// ----------------------------------------------------------------------------
// utf8_safe_text_checker_defines.svh
// Assertion macros shared by the text checker RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_SAFE_TEXT_CHECKER_DEFINES_SVH
`define UTF8_SAFE_TEXT_CHECKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define U8C_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8chk assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define U8C_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8chk assertion failed");

`endif

/* hdl/u8chk_pkg.sv */
// ----------------------------------------------------------------------------
// u8chk_pkg
// Types, constants and the lead byte decoder of the UTF-8 text checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8chk_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] owed_t;

  localparam byte_t END_BYTE   = 8'h00;
  localparam byte_t CTRL_LIMIT = 8'h20;
  localparam byte_t DEL_BYTE   = 8'h7f;
  localparam byte_t CONT_LOW   = 8'h80;
  localparam byte_t CONT_HIGH  = 8'hbf;
  localparam byte_t E0_LOW     = 8'ha0;
  localparam byte_t ED_HIGH    = 8'h9f;
  localparam byte_t F0_LOW     = 8'h90;
  localparam byte_t F4_HIGH    = 8'h8f;

  localparam owed_t OWED_NONE  = 2'd0;
  localparam owed_t OWED_ONE   = 2'd1;
  localparam owed_t OWED_TWO   = 2'd2;
  localparam owed_t OWED_THREE = 2'd3;

  typedef struct packed {
    logic  bad;
    owed_t owed;
    byte_t low;
    byte_t high;
  } lead_t;

  function automatic lead_t decode_lead(input byte_t b);
    lead_t d;
    d.bad  = 1'b0;
    d.owed = OWED_NONE;
    d.low  = CONT_LOW;
    d.high = CONT_HIGH;
    case (b) inside
      [8'h00:8'h1f], DEL_BYTE: d.bad = 1'b1;
      [8'h20:8'h7e]: ;
      [8'hc2:8'hdf]: d.owed = OWED_ONE;
      8'he0: begin
        d.owed = OWED_TWO;
        d.low  = E0_LOW;
      end
      8'hed: begin
        d.owed = OWED_TWO;
        d.high = ED_HIGH;
      end
      [8'he1:8'hef]: d.owed = OWED_TWO;
      8'hf0: begin
        d.owed = OWED_THREE;
        d.low  = F0_LOW;
      end
      [8'hf1:8'hf3]: d.owed = OWED_THREE;
      8'hf4: begin
        d.owed = OWED_THREE;
        d.high = F4_HIGH;
      end
      default: d.bad = 1'b1;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/u8chk_ifs.sv */
// ----------------------------------------------------------------------------
// u8chk_ifs
// Valid/ready channels of the UTF-8 text checker: byte in, verdict out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface u8chk_byte_if;
  logic               valid;
  logic               ready;
  u8chk_pkg::byte_t   text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface u8chk_flag_if;
  logic valid;
  logic ready;
  logic text_safe;

  modport source (output valid, output text_safe, input ready);
  modport sink   (input valid, input text_safe, output ready);
endinterface

`default_nettype wire

/* hdl/utf8_safe_text_checker.sv */
// ----------------------------------------------------------------------------
// utf8_safe_text_checker
// Strict printable UTF-8 check of a zero-terminated byte stream.
//
//   channel  | dir | payload        | item
//   in_ch    | in  | text_byte [7:0]| one text byte, 0 ends the text
//   out_ch   | out | text_safe      | one verdict per ended text
//
// One byte per clock unless in_ch stalls; the decode of a byte is a single pass from the port
// into the sequence state and the verdict register.
// A verdict appears in the cycle after its zero byte is taken.
// rst_n (sync, active low) clears the sequence state and the verdict slot.
// in_ch stalls only while an untaken verdict sits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_safe_text_checker (
  input  wire            clk,
  input  wire            rst_n,
  u8chk_byte_if.sink     in_ch,
  u8chk_flag_if.source   out_ch
);

  `include "utf8_safe_text_checker_defines.svh"

  u8chk_pkg::owed_t owed_r, owed_nxt;
  u8chk_pkg::byte_t low_r, low_nxt;
  u8chk_pkg::byte_t high_r, high_nxt;
  logic             err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_safe_r, out_safe_nxt;

  logic             in_acc;
  logic             is_end;
  logic             end_acc;
  logic             owed_none;
  logic             end_safe;
  logic             idle_bounds;
  u8chk_pkg::lead_t lead;

  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign is_end        = (in_ch.text_byte == u8chk_pkg::END_BYTE);
  assign end_acc       = in_acc && is_end;
  assign owed_none     = (owed_r == u8chk_pkg::OWED_NONE);
  assign end_safe      = !err_r && owed_none;
  assign idle_bounds   = (low_r == u8chk_pkg::CONT_LOW) && (high_r == u8chk_pkg::CONT_HIGH);
  assign lead          = u8chk_pkg::decode_lead(in_ch.text_byte);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.text_safe = out_safe_r;

  always_comb begin
    owed_nxt      = owed_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_safe_nxt  = out_safe_r;
    if (in_acc) begin
      if (is_end) begin
        out_valid_nxt = 1'b1;
        out_safe_nxt  = end_safe;
        owed_nxt      = u8chk_pkg::OWED_NONE;
        low_nxt       = u8chk_pkg::CONT_LOW;
        high_nxt      = u8chk_pkg::CONT_HIGH;
        err_nxt       = 1'b0;
      end else if (!err_r) begin
        if (owed_r != u8chk_pkg::OWED_NONE) begin
          if (in_ch.text_byte >= low_r && in_ch.text_byte <= high_r) begin
            owed_nxt = owed_r - u8chk_pkg::OWED_ONE;
            low_nxt  = u8chk_pkg::CONT_LOW;
            high_nxt = u8chk_pkg::CONT_HIGH;
          end else begin
            err_nxt = 1'b1;
          end
        end else if (lead.bad) begin
          err_nxt = 1'b1;
        end else begin
          owed_nxt = lead.owed;
          low_nxt  = lead.low;
          high_nxt = lead.high;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r      <= u8chk_pkg::OWED_NONE;
      low_r       <= u8chk_pkg::CONT_LOW;
      high_r      <= u8chk_pkg::CONT_HIGH;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      owed_r      <= owed_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_safe_r <= out_safe_nxt;
  end

  `U8C_ASSERT_NOW(a_idle_bounds, owed_none, idle_bounds)
  `U8C_ASSERT_NEXT(a_end_clears, end_acc, owed_none && !err_r)
  `U8C_ASSERT_NEXT(a_verdict, end_acc, out_valid_r && out_safe_r == $past(end_safe))
  `U8C_ASSERT_NEXT(a_err_sticky, err_r && !end_acc, err_r)
  `U8C_ASSERT_NOW(a_stall_back, out_valid_r && !out_ch.ready, !in_ch.ready)

endmodule

`default_nettype wire

/* sim/utf8_safe_text_checker_test.sv */
// ----------------------------------------------------------------------------
// utf8_safe_text_checker_test
// Self-checking bench for the strict printable UTF-8 text checker. A queue of
// zero-terminated texts (a short directed set, then random texts built mostly
// from well-formed code points with some noise, corrupted and cut-off
// sequences) is fed one byte per item with random gaps. A scanner model
// tracks the sequence state and queues one verdict per zero byte; the monitor
// compares each verdict item against the oldest queued one. The receiver
// stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_safe_text_checker_test;

  localparam int RANDOM_ITEMS = 1850;
  localparam int MAX_GAP      = 12;
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 10;

  localparam u8chk_pkg::byte_t DIRECTED [32] = '{
    8'h20, 8'h7e, 8'hc2, 8'h80, 8'hdf, 8'hbf, 8'h00,
    8'h00,
    8'h1f, 8'h41, 8'h00,
    8'h7f, 8'h00,
    8'he0, 8'h9f, 8'h00,
    8'hed, 8'ha0, 8'h00,
    8'hf4, 8'h90, 8'h00,
    8'hf0, 8'h90, 8'h80, 8'h80, 8'h00,
    8'hff, 8'h00,
    8'he1, 8'h80, 8'h00
  };

  localparam int unsigned EDGE_POINTS [14] = '{
    32'h20, 32'h7e, 32'h80, 32'h7ff, 32'h800, 32'hd7ff, 32'hd800,
    32'hdfff, 32'he000, 32'hffff, 32'h10000, 32'h10ffff, 32'h110000, 32'h3ffff
  };

  logic clk;
  logic rst_n;

  u8chk_byte_if in_ch ();
  u8chk_flag_if out_ch ();

  utf8_safe_text_checker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  u8chk_pkg::byte_t text_q [$];
  bit               verdict_q [$];
  int               fail_count = 0;

  u8chk_pkg::owed_t scan_owed;
  u8chk_pkg::byte_t scan_low;
  u8chk_pkg::byte_t scan_high;
  bit               scan_bad;

  bit in_fire  = 1'b0;
  bit out_fire = 1'b0;
  bit tx_busy  = 1'b0;
  bit tx_calm  = 1'b0;
  int tx_gap   = 0;
  int tx_sent  = 0;
  bit rx_calm  = 1'b0;
  int rx_hold  = 0;
  int rx_seen  = 0;
  int stall_cycles = 0;

  task automatic clear_scan();
    scan_owed = u8chk_pkg::OWED_NONE;
    scan_low  = u8chk_pkg::CONT_LOW;
    scan_high = u8chk_pkg::CONT_HIGH;
    scan_bad  = 1'b0;
  endtask

  task automatic open_sequence(input u8chk_pkg::owed_t owed, input u8chk_pkg::byte_t lo,
                               input u8chk_pkg::byte_t hi);
    scan_owed = owed;
    scan_low  = lo;
    scan_high = hi;
  endtask

  task automatic scan_text_byte(input u8chk_pkg::byte_t b, output bit ended, output bit safe);
    ended = 1'b0;
    safe  = 1'b0;
    if (b == u8chk_pkg::END_BYTE) begin
      ended = 1'b1;
      safe  = !scan_bad && (scan_owed == u8chk_pkg::OWED_NONE);
      clear_scan();
    end else if (!scan_bad) begin
      if (scan_owed != u8chk_pkg::OWED_NONE) begin
        if (b >= scan_low && b <= scan_high) begin
          open_sequence(u8chk_pkg::owed_t'(scan_owed - 2'd1),
                        u8chk_pkg::CONT_LOW, u8chk_pkg::CONT_HIGH);
        end else begin
          scan_bad = 1'b1;
        end
      end else if (b < u8chk_pkg::CTRL_LIMIT || b == u8chk_pkg::DEL_BYTE) begin
        scan_bad = 1'b1;
      end else if (b < u8chk_pkg::CONT_LOW) begin
      end else if (b >= 8'hc2 && b <= 8'hdf) begin
        open_sequence(u8chk_pkg::OWED_ONE, u8chk_pkg::CONT_LOW, u8chk_pkg::CONT_HIGH);
      end else if (b == 8'he0) begin
        open_sequence(u8chk_pkg::OWED_TWO, u8chk_pkg::E0_LOW, u8chk_pkg::CONT_HIGH);
      end else if (b == 8'hed) begin
        open_sequence(u8chk_pkg::OWED_TWO, u8chk_pkg::CONT_LOW, u8chk_pkg::ED_HIGH);
      end else if (b >= 8'he1 && b <= 8'hef) begin
        open_sequence(u8chk_pkg::OWED_TWO, u8chk_pkg::CONT_LOW, u8chk_pkg::CONT_HIGH);
      end else if (b == 8'hf0) begin
        open_sequence(u8chk_pkg::OWED_THREE, u8chk_pkg::F0_LOW, u8chk_pkg::CONT_HIGH);
      end else if (b >= 8'hf1 && b <= 8'hf3) begin
        open_sequence(u8chk_pkg::OWED_THREE, u8chk_pkg::CONT_LOW, u8chk_pkg::CONT_HIGH);
      end else if (b == 8'hf4) begin
        open_sequence(u8chk_pkg::OWED_THREE, u8chk_pkg::CONT_LOW, u8chk_pkg::F4_HIGH);
      end else begin
        scan_bad = 1'b1;
      end
    end
  endtask

  // one code point, mostly well-formed; sometimes noise, a bad or missing tail
  task automatic add_random_char();
    u8chk_pkg::byte_t seq [4];
    int unsigned      cp;
    int               n;
    int               pick;
    case ($urandom_range(0, 5))
      0, 1, 2: cp = $urandom_range(32'h20, 32'h7e);
      3:       cp = $urandom_range(32'h80, 32'h7ff);
      4:       cp = $urandom_range(32'h800, 32'hffff);
      default: cp = $urandom_range(32'h10000, 32'h10ffff);
    endcase
    if ($urandom_range(0, 9) == 0) cp = EDGE_POINTS[$urandom_range(0, 13)];
    if (cp < 32'h80) begin
      seq[0] = cp[7:0];
      n = 1;
    end else if (cp < 32'h800) begin
      seq[0] = 8'hc0 | cp[10:6];
      seq[1] = 8'h80 | cp[5:0];
      n = 2;
    end else if (cp < 32'h10000) begin
      seq[0] = 8'he0 | cp[15:12];
      seq[1] = 8'h80 | cp[11:6];
      seq[2] = 8'h80 | cp[5:0];
      n = 3;
    end else begin
      seq[0] = 8'hf0 | cp[20:18];
      seq[1] = 8'h80 | cp[17:12];
      seq[2] = 8'h80 | cp[11:6];
      seq[3] = 8'h80 | cp[5:0];
      n = 4;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      seq[0] = u8chk_pkg::byte_t'($urandom_range(1, 255));
      n = 1;
    end else if (pick < 7 && n > 1) begin
      seq[$urandom_range(1, n - 1)] = u8chk_pkg::byte_t'($urandom_range(1, 255));
    end else if (pick < 10 && n > 1) begin
      n = $urandom_range(1, n - 1);
    end
    for (int i = 0; i < n; i++) text_q.push_back(seq[i]);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : stimulus
    int n_chars;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.text_byte  = u8chk_pkg::END_BYTE;
    out_ch.ready     = 1'b0;
    clear_scan();
    foreach (DIRECTED[i]) text_q.push_back(DIRECTED[i]);
    while (text_q.size() < RANDOM_ITEMS + $size(DIRECTED)) begin
      n_chars = $urandom_range(0, 10);
      repeat (n_chars) add_random_char();
      text_q.push_back(u8chk_pkg::END_BYTE);
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    while (text_q.size() != 0 || tx_busy) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // byte driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (tx_busy && in_fire) begin
        tx_busy = 1'b0;
        tx_sent++;
        if (tx_sent % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        tx_gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (text_q.size() != 0) begin
          in_ch.text_byte <= text_q.pop_front();
          tx_busy = 1'b1;
        end
      end
      in_ch.valid <= tx_busy;
    end
  end

  // verdict receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) begin
        rx_seen++;
        if (rx_seen % 8 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        rx_hold = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin : monitor
    bit ended;
    bit safe;
    bit want;
    in_fire  <= rst_n && in_ch.valid && in_ch.ready;
    out_fire <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        scan_text_byte(in_ch.text_byte, ended, safe);
        if (ended) verdict_q.push_back(safe);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $error("text_safe: no verdict expected, actual %0b", out_ch.text_safe);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.text_safe !== want) begin
            $error("text_safe: expected %0b, actual %0b", want, out_ch.text_safe);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/u8chk_pkg.sv
hdl/u8chk_ifs.sv
hdl/utf8_safe_text_checker.sv
sim/utf8_safe_text_checker_test.sv
